// ----- src/kdh_pkg.sv -----
package kdh_pkg;

  localparam int NUM_KEYS    = 7;
  localparam int HISTORY_LEN = 4;
  localparam int TIME_W      = 32;
  localparam int KEY_IDX_W   = 3;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  typedef logic [NUM_KEYS-1:0]    key_vec_t;
  typedef logic [HISTORY_LEN-1:0] hist_t;
  typedef logic [TIME_W-1:0]      ms_t;

  // one input item
  typedef struct packed {
    cmd_t                 command;
    key_vec_t             key_samples;
    ms_t                  now_ms;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 once_only;
    ms_t                  min_hold_ms;
  } item_t;

  // one result item
  typedef struct packed {
    key_vec_t key_states;
    logic     pressed;
    ms_t      hold_ms;
  } result_t;

  // input register contents handed to the core
  typedef struct packed {
    logic  valid;
    item_t item;
  } staged_t;

endpackage

// ----- src/kdh_if.sv -----
interface kdh_req_if import kdh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  key_vec_t             key_samples;
  ms_t                  now_ms;
  logic [KEY_IDX_W-1:0] key_index;
  logic                 once_only;
  ms_t                  min_hold_ms;

  modport source (output valid, command, key_samples, now_ms, key_index, once_only,
                  min_hold_ms, input ready);
  modport sink (input valid, command, key_samples, now_ms, key_index, once_only,
                min_hold_ms, output ready);
endinterface

interface kdh_rsp_if import kdh_pkg::*; ();
  logic     valid;
  logic     ready;
  key_vec_t key_states;
  logic     pressed;
  ms_t      hold_ms;

  modport source (output valid, key_states, pressed, hold_ms, input ready);
  modport sink (input valid, key_states, pressed, hold_ms, output ready);
endinterface

// ----- src/kdh_in_reg.sv -----
module kdh_in_reg import kdh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  kdh_req_if.sink    req,
  output staged_t    staged
);

  logic  valid;
  item_t item;

  assign req.ready = advance;

  // valid flag of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= req.valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (advance && req.valid) begin
      item.command     <= req.command;
      item.key_samples <= req.key_samples;
      item.now_ms      <= req.now_ms;
      item.key_index   <= req.key_index;
      item.once_only   <= req.once_only;
      item.min_hold_ms <= req.min_hold_ms;
    end
  end

  assign staged.valid = valid;
  assign staged.item  = item;

endmodule

// ----- src/kdh_core.sv -----
module kdh_core import kdh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  staged_t staged,
  output result_t res
);

  key_vec_t debounced;
  key_vec_t debounced_next;
  key_vec_t acked;
  key_vec_t acked_next;
  hist_t    history [NUM_KEYS];
  hist_t    history_next [NUM_KEYS];
  ms_t      press_time [NUM_KEYS];
  key_vec_t press_we;
  logic     fire;
  logic     is_down;
  ms_t      hold;
  logic     pressed;

  assign fire = staged.valid && advance;

  // debounce update on a tick, acknowledge handling on a query
  always_comb begin
    debounced_next = debounced;
    acked_next     = acked;
    history_next   = history;
    press_we       = '0;
    is_down        = 1'b0;
    hold           = '0;
    pressed        = 1'b0;
    if (staged.item.command == CMD_SAMPLE) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        // flip once the last samples agree and the new level disagrees
        if ((staged.item.key_samples[k] == debounced[k]) &&
            ((history[k] == '0) || (history[k] == '1))) begin
          debounced_next[k] = ~staged.item.key_samples[k];
          acked_next[k]     = 1'b0;
          press_we[k]       = ~staged.item.key_samples[k];
        end
        history_next[k] = {history[k][HISTORY_LEN-2:0], staged.item.key_samples[k]};
      end
    end else if (32'(staged.item.key_index) < NUM_KEYS) begin
      is_down = debounced[staged.item.key_index];
      if (is_down) begin
        hold = staged.item.now_ms - press_time[staged.item.key_index];
      end
      if (is_down && (hold >= staged.item.min_hold_ms) &&
          !(staged.item.once_only && acked[staged.item.key_index])) begin
        if (staged.item.once_only) begin
          acked_next[staged.item.key_index] = 1'b1;
        end
        pressed = 1'b1;
      end
    end
  end

  // key state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounced <= '0;
      acked     <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        history[k] <= (k == 0) ? '1 : '0;
      end
    end else if (fire) begin
      debounced <= debounced_next;
      acked     <= acked_next;
      history   <= history_next;
    end
  end

  // press time per key, written on a debounced press
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (fire && press_we[k]) begin
        press_time[k] <= staged.item.now_ms;
      end
    end
  end

  assign res.key_states = debounced_next;
  assign res.pressed    = pressed;
  assign res.hold_ms    = hold;

endmodule

// ----- src/kdh_out_reg.sv -----
module kdh_out_reg import kdh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  staged_t    staged,
  input  result_t    res,
  output logic       advance,
  kdh_rsp_if.source  rsp
);

  logic    valid;
  result_t held;

  // the pipe moves when the result register is empty or being drained
  assign advance = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= staged.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && staged.valid) begin
      held <= res;
    end
  end

  assign rsp.valid      = valid;
  assign rsp.key_states = held.key_states;
  assign rsp.pressed    = held.pressed;
  assign rsp.hold_ms    = held.hold_ms;

endmodule

// ----- src/key_debouncer_with_hold_timing_unit.sv -----
// channel | dir | beat contents
// req     | in  | command, key_samples, now_ms, key_index, once_only, min_hold_ms
// rsp     | out | key_states, pressed, hold_ms
//
// one beat per cycle sustained while rsp is not stalled; a result is presented after its request beat
// latency is set by the input register and the result register around the key logic
// all seven keys are updated in parallel within the single logic stage
// rst (synchronous) clears debounced states, acknowledges and history; key 0 history
// resets to all ones; press times are not reset and are only read after a press
// a stalled rsp holds the whole pipe; req.ready follows rsp.ready while rsp.valid is high
module key_debouncer_with_hold_timing_unit import kdh_pkg::*; (
  input logic        clk,
  input logic        rst,
  kdh_req_if.sink    req,
  kdh_rsp_if.source  rsp
);

  logic    advance;
  staged_t staged;
  result_t res;

  kdh_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .staged  (staged)
  );

  kdh_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .staged  (staged),
    .res     (res)
  );

  kdh_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .staged  (staged),
    .res     (res),
    .advance (advance),
    .rsp     (rsp)
  );

endmodule

// ----- tb/sv/tb_key_debouncer_with_hold_timing_unit.sv -----
`timescale 1ns / 1ps

module tb_key_debouncer_with_hold_timing_unit;
  import kdh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 370;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;

  kdh_req_if req ();
  kdh_rsp_if rsp ();

  key_debouncer_with_hold_timing_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // beats waiting to be sent and results still owed by the block
  item_t   pending_items[$];
  result_t expected_results[$];

  // own copy of the key state
  key_vec_t db_down;
  key_vec_t ack_bits;
  hist_t    hist_bits [NUM_KEYS];
  ms_t      press_ms  [NUM_KEYS];

  // stimulus state: intended pin levels and the running millisecond clock
  key_vec_t intended_levels;
  ms_t      clock_ms;

  int send_idle_pct;
  int stall_pct;
  int error_count;
  int cycle_count;
  logic req_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // debounce a sample tick or answer a query, updating the key state
  function automatic result_t debounce_and_query(input item_t it);
    result_t r;
    logic    lvl;
    logic    idle_hist;
    r = '0;
    if (it.command == CMD_SAMPLE) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        lvl = it.key_samples[k];
        idle_hist = (hist_bits[k] == '0) || (hist_bits[k] == '1);
        // level agreeing with the pressed bit means a change of state for an active-low pin
        if (lvl == db_down[k] && idle_hist) begin
          ack_bits[k] = 1'b0;
          if (lvl) begin
            db_down[k] = 1'b0;
          end else begin
            db_down[k] = 1'b1;
            press_ms[k] = it.now_ms;
          end
        end
        hist_bits[k] = {hist_bits[k][HISTORY_LEN-2:0], lvl};
      end
    end else if (it.key_index < NUM_KEYS) begin
      if (db_down[it.key_index]) begin
        r.hold_ms = it.now_ms - press_ms[it.key_index];
      end
      if (db_down[it.key_index] && r.hold_ms >= it.min_hold_ms &&
          !(it.once_only && ack_bits[it.key_index])) begin
        if (it.once_only) begin
          ack_bits[it.key_index] = 1'b1;
        end
        r.pressed = 1'b1;
      end
    end
    r.key_states = db_down;
    return r;
  endfunction

  task automatic push_item(input cmd_t cmd, input key_vec_t lv, input ms_t t,
                           input logic [KEY_IDX_W-1:0] idx, input logic once,
                           input ms_t min_hold);
    item_t it;
    it.command     = cmd;
    it.key_samples = lv;
    it.now_ms      = t;
    it.key_index   = idx;
    it.once_only   = once;
    it.min_hold_ms = min_hold;
    pending_items.push_back(it);
  endtask

  task automatic push_tick(input key_vec_t lv, input ms_t t);
    push_item(CMD_SAMPLE, lv, t, KEY_IDX_W'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic push_query(input logic [KEY_IDX_W-1:0] idx, input logic once,
                            input ms_t min_hold, input ms_t t);
    push_item(CMD_QUERY, key_vec_t'($urandom), t, idx, once, min_hold);
  endtask

  // mostly clean press and release sequences, with bounce and some pure noise
  task automatic queue_random_items(input int n);
    int       sel;
    key_vec_t lv;
    logic [KEY_IDX_W-1:0] idx;
    ms_t      min_hold;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 62) begin
        if ($urandom_range(0, 59) == 0) begin
          clock_ms = $urandom;
        end else begin
          clock_ms = clock_ms + $urandom_range(1, 25);
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
          if ($urandom_range(0, 29) == 0) begin
            intended_levels[k] = ~intended_levels[k];
          end
        end
        lv = intended_levels;
        for (int k = 0; k < NUM_KEYS; k++) begin
          if ($urandom_range(0, 39) == 0) begin
            lv[k] = ~lv[k];
          end
        end
        if (sel < 3) begin
          lv = key_vec_t'($urandom);
        end
        push_tick(lv, clock_ms);
      end else begin
        idx = ($urandom_range(0, 11) == 0) ? KEY_IDX_W'(NUM_KEYS) :
              KEY_IDX_W'($urandom_range(0, NUM_KEYS - 1));
        case ($urandom_range(0, 5))
          0: min_hold = '0;
          1: min_hold = $urandom;
          default: min_hold = $urandom_range(0, 400);
        endcase
        if ($urandom_range(0, 19) == 0) begin
          push_query(idx, 1'($urandom), min_hold, $urandom);
        end else begin
          push_query(idx, 1'($urandom), min_hold, clock_ms + $urandom_range(0, 5));
        end
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_items.size() != 0 || req.valid) @(posedge clk);
  endtask

  task automatic wait_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // driver: new beat or idle at the falling edge
  always @(negedge clk) begin
    item_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      if (!req.valid || req_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          req.command     <= nxt.command;
          req.key_samples <= nxt.key_samples;
          req.now_ms      <= nxt.now_ms;
          req.key_index   <= nxt.key_index;
          req.once_only   <= nxt.once_only;
          req.min_hold_ms <= nxt.min_hold_ms;
          req.valid       <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: check result beats, then predict for accepted request beats
  always @(posedge clk) begin
    item_t   got_item;
    result_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req.valid && req.ready;
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result key_states=%h pressed=%b hold_ms=%h",
                   $time, rsp.key_states, rsp.pressed, rsp.hold_ms);
          error_count = error_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (rsp.key_states !== want.key_states) begin
            $display("%0t: key_states expected %h actual %h",
                     $time, want.key_states, rsp.key_states);
            error_count = error_count + 1;
          end
          if (rsp.pressed !== want.pressed) begin
            $display("%0t: pressed expected %b actual %b", $time, want.pressed, rsp.pressed);
            error_count = error_count + 1;
          end
          if (rsp.hold_ms !== want.hold_ms) begin
            $display("%0t: hold_ms expected %h actual %h", $time, want.hold_ms, rsp.hold_ms);
            error_count = error_count + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        got_item.command     = req.command;
        got_item.key_samples = req.key_samples;
        got_item.now_ms      = req.now_ms;
        got_item.key_index   = req.key_index;
        got_item.once_only   = req.once_only;
        got_item.min_hold_ms = req.min_hold_ms;
        expected_results.push_back(debounce_and_query(got_item));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.command     = CMD_SAMPLE;
    req.key_samples = '0;
    req.now_ms      = '0;
    req.key_index   = '0;
    req.once_only   = 1'b0;
    req.min_hold_ms = '0;
    rsp.ready       = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    db_down         = '0;
    ack_bits        = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hist_bits[k] = '0;
      press_ms[k]  = '0;
    end
    hist_bits[0]    = '1;
    intended_levels = '1;
    clock_ms        = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // released key with zero minimum hold, and a key index past the last key
    push_query(3'd0, 1'b0, '0, 32'd0);
    push_query(KEY_IDX_W'(NUM_KEYS), 1'b1, '0, 32'd0);
    // all released, query fields at their maximum are ignored on a tick
    push_item(CMD_SAMPLE, 7'h7F, 32'hFFFF_FFF0, 3'd7, 1'b1, 32'hFFFF_FFFF);
    // key 0 starts settled high, so it presses at once; press time near the wrap
    push_item(CMD_SAMPLE, 7'h00, 32'hFFFF_FFF8, 3'd0, 1'b0, '0);
    // once-only acknowledge, repeat, plain mode, hold too short
    push_query(3'd0, 1'b1, '0, 32'd5);
    push_query(3'd0, 1'b1, '0, 32'd6);
    push_query(3'd0, 1'b0, '0, 32'd7);
    push_query(3'd0, 1'b0, 32'hFFFF_FFFF, 32'd8);
    push_query(3'd0, 1'b1, 32'd100, 32'd20);
    // the other keys need a settled history before they press
    for (int i = 0; i < 5; i++) push_tick(7'h00, 32'd30 + i);
    // query with samples that must be ignored
    push_item(CMD_QUERY, 7'h7F, 32'd40, 3'd3, 1'b1, '0);
    push_query(3'd6, 1'b0, 32'd3, 32'd41);
    // release all, then a bounce straight back is rejected
    push_tick(7'h7F, 32'd50);
    push_query(3'd0, 1'b0, '0, 32'd51);
    push_tick(7'h00, 32'd52);
    push_query(3'd6, 1'b1, '0, 32'd53);
    push_tick(7'h7F, 32'd54);
    wait_sent();
    wait_results();

    // idling phases: none, sender, receiver, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      queue_random_items(ITEMS_PER_PHASE / 2);
      wait_sent();
      // hold off until the block has delivered everything owed
      wait_results();
      queue_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
      wait_sent();
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
